>>> design/spi_command_framer_with_poll_defines.svh
// ----------------------------------------------------------------------------
// SPI command framer - assertion macros
// Shared concurrent assertion forms for the framer modules.
// ----------------------------------------------------------------------------
`ifndef SPI_COMMAND_FRAMER_WITH_POLL_DEFINES_SVH
`define SPI_COMMAND_FRAMER_WITH_POLL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/scfp_pkg.sv
// ----------------------------------------------------------------------------
// SPI command framer - package
// Codes, tables, frame record and helpers shared by the framer modules.
// ----------------------------------------------------------------------------
package scfp_pkg;

   localparam int unsigned FRAME_BYTES = 12;
   localparam int unsigned FRAME_BITS  = 8 * FRAME_BYTES;

   // register file
   localparam logic        CSR_POLL_LIMIT   = 1'b0;
   localparam logic        CSR_MAX_BURST    = 1'b1;
   localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;
   localparam logic [15:0] MAX_BURST_RESET  = 16'h2000;

   localparam logic [7:0]  RX_READY = 8'h01;
   localparam logic [7:0]  DUMMY    = 8'h00;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BURST = 2'd1,
      OP_RX    = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [3:0] CMD_READ    = 4'd0;
   localparam logic [3:0] CMD_WRITE   = 4'd1;
   localparam logic [3:0] CMD_BURST   = 4'd2;
   localparam logic [3:0] CMD_INVALID = 4'd15;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_IO      = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_BURST = 4'b0010,
      PH_POLL  = 4'b0100,
      PH_READ  = 4'b1000
   } phase_type;

   // One burst of results: bytes leave from the top, count of results left.
   typedef struct packed {
      logic [FRAME_BITS-1:0] bytes;
      logic [3:0]            count;
      logic                  tx;
      logic                  done;
      status_type            status;
      logic [31:0]           read_data;
   } frame_type;

   function automatic logic [7:0] cmd_code(input logic [3:0] cmd);
      logic [7:0] code;
      case (cmd)
         4'd0:    code = 8'h02;
         4'd1:    code = 8'h03;
         4'd2:    code = 8'h04;
         4'd3:    code = 8'h03;
         4'd4:    code = 8'h02;
         4'd5:    code = 8'h0B;
         4'd6:    code = 8'h0A;
         4'd7:    code = 8'h1A;
         4'd8:    code = 8'hC1;
         4'd9:    code = 8'hC0;
         4'd10:   code = 8'hC2;
         4'd11:   code = 8'h9E;
         4'd12:   code = 8'h9F;
         4'd13:   code = 8'h01;
         4'd14:   code = 8'hA0;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // allowed granularity flags per command; none for the invalid index
   function automatic logic [2:0] gran_mask(input logic [3:0] cmd);
      logic [2:0] mask;
      if (cmd <= 4'd8) begin
         mask = 3'b001;
      end else if (cmd <= 4'd10) begin
         mask = 3'b011;
      end else if (cmd <= 4'd14) begin
         mask = 3'b100;
      end else begin
         mask = 3'b000;
      end
      return mask;
   endfunction

   function automatic frame_type done_frame(input status_type st, input logic [31:0] rd);
      frame_type f;
      f           = '0;
      f.count     = 4'd1;
      f.done      = 1'b1;
      f.status    = st;
      f.read_data = rd;
      return f;
   endfunction

   function automatic frame_type dummy_frame();
      frame_type f;
      f       = '0;
      f.count = 4'd1;
      f.tx    = 1'b1;
      return f;
   endfunction

endpackage

>>> design/scfp_csr.sv
// ----------------------------------------------------------------------------
// SPI command framer - register file
// APB-style access to the poll limit and the burst limit.
// ----------------------------------------------------------------------------
module scfp_csr
   import scfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [15:0] poll_limit,
   output logic [15:0] max_burst
);

   logic [15:0] poll_limit_ff, poll_limit_in;
   logic [15:0] max_burst_ff, max_burst_in;
   logic        wr_en;
   logic        reg_sel;

   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      poll_limit_in = poll_limit_ff;
      max_burst_in  = max_burst_ff;
      if (wr_en) begin
         case (reg_sel)
            CSR_POLL_LIMIT: poll_limit_in = pwdata[15:0];
            CSR_MAX_BURST:  max_burst_in  = pwdata[15:0];
            default:        poll_limit_in = poll_limit_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         CSR_POLL_LIMIT: prdata = {16'h0000, poll_limit_ff};
         CSR_MAX_BURST:  prdata = {16'h0000, max_burst_ff};
         default:        prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= POLL_LIMIT_RESET;
         max_burst_ff  <= MAX_BURST_RESET;
      end else begin
         poll_limit_ff <= poll_limit_in;
         max_burst_ff  <= max_burst_in;
      end
   end

   assign poll_limit = poll_limit_ff;
   assign max_burst  = max_burst_ff;

endmodule

>>> design/scfp_framer.sv
// ----------------------------------------------------------------------------
// SPI command framer - command decode
// Turns one item and the command state into a frame of results.
// ----------------------------------------------------------------------------
`include "spi_command_framer_with_poll_defines.svh"

module scfp_framer
   import scfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [1:0]  operation,
   input  logic [3:0]  command,
   input  logic [2:0]  granularity,
   input  logic [31:0] address,
   input  logic [15:0] length,
   input  logic [31:0] data_word,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] poll_limit,
   input  logic [15:0] max_burst,
   output frame_type   frame
);

   phase_type   phase_ff, phase_in;
   logic [15:0] words_ff, words_in;
   logic [15:0] poll_ff, poll_in;
   logic [1:0]  index_ff, index_in;
   logic [31:0] shift_ff, shift_in;
   logic [15:0] len_field;
   logic [63:0] header;
   logic        cmd_ok;

   assign cmd_ok    = (command != CMD_INVALID) && ((granularity & gran_mask(command)) != 3'b000);
   assign len_field = (command == CMD_BURST) ? (length - 16'd1) : 16'h0000;
   assign header    = {len_field, 8'h00, cmd_code(command), address};

   always_comb begin
      frame    = '0;
      phase_in = phase_ff;
      words_in = words_ff;
      poll_in  = poll_ff;
      index_in = index_ff;
      shift_in = shift_ff;
      case (op_type'(operation))
         OP_START: begin
            phase_in = PH_IDLE;
            words_in = 16'h0000;
            if (!cmd_ok || (command == CMD_BURST && length > max_burst)) begin
               frame = done_frame(ST_INVALID, 32'h0);
            end else if (command > CMD_BURST) begin
               frame = done_frame(ST_OK, 32'h0);
            end else if (command == CMD_BURST && length == 16'h0000) begin
               frame = done_frame(ST_IO, 32'h0);
            end else if (command == CMD_READ) begin
               frame.bytes = {header, DUMMY, 24'h000000};
               frame.count = 4'd9;
               frame.tx    = 1'b1;
               phase_in    = PH_POLL;
               poll_in     = 16'h0000;
               index_in    = 2'd0;
               shift_in    = 32'h0;
            end else begin
               frame.bytes = {header, data_word};
               frame.count = 4'd12;
               frame.tx    = 1'b1;
               if (command == CMD_BURST && length > 16'd1) begin
                  phase_in = PH_BURST;
                  words_in = length - 16'd1;
               end else begin
                  frame.done = 1'b1;
               end
            end
         end
         OP_BURST: begin
            if (phase_ff == PH_BURST) begin
               frame.bytes = {data_word, 64'h0};
               frame.count = 4'd4;
               frame.tx    = 1'b1;
               words_in    = words_ff - 16'd1;
               if (words_in == 16'h0000) begin
                  phase_in   = PH_IDLE;
                  frame.done = 1'b1;
               end
            end
         end
         OP_RX: begin
            if (phase_ff == PH_POLL) begin
               if (rx_byte == RX_READY) begin
                  phase_in = PH_READ;
                  index_in = 2'd0;
                  shift_in = 32'h0;
                  frame    = dummy_frame();
               end else begin
                  poll_in = poll_ff + 16'd1;
                  if (poll_in >= poll_limit) begin
                     phase_in = PH_IDLE;
                     frame    = done_frame(ST_TIMEOUT, 32'h0);
                  end else begin
                     frame = dummy_frame();
                  end
               end
            end else if (phase_ff == PH_READ) begin
               shift_in = {shift_ff[23:0], rx_byte};
               index_in = index_ff + 2'd1;
               if (index_in == 2'd0) begin
                  phase_in = PH_IDLE;
                  frame    = done_frame(ST_OK, shift_in);
               end else begin
                  frame = dummy_frame();
               end
            end
         end
         default: begin
            frame = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         words_ff <= 16'h0000;
         poll_ff  <= 16'h0000;
         index_ff <= 2'd0;
         shift_ff <= 32'h0;
      end else if (advance) begin
         phase_ff <= phase_in;
         words_ff <= words_in;
         poll_ff  <= poll_in;
         index_ff <= index_in;
         shift_ff <= shift_in;
      end
   end

   `SCFP_ASSERT_NOW(a_burst_has_words, phase_ff == PH_BURST, words_ff != 16'h0000, "burst phase with no words left")
   `SCFP_ASSERT_NEXT(a_start_not_read, advance && operation == OP_START, phase_ff != PH_READ, "start item left read phase")
   `SCFP_ASSERT_NOW(a_multi_is_tx, frame.count > 4'd1, frame.tx && frame.count <= 4'd12, "multi-result frame without bytes")

endmodule

>>> design/scfp_serializer.sv
// ----------------------------------------------------------------------------
// SPI command framer - result serializer
// Holds one frame and hands its results out one per accepted transfer.
// ----------------------------------------------------------------------------
`include "spi_command_framer_with_poll_defines.svh"

module scfp_serializer
   import scfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  frame_type   frame,
   output logic        free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_data
);

   frame_type frm_ff, frm_in;
   logic      fire;

   assign rsp_valid = frm_ff.count != 4'd0;
   assign rsp_last  = frm_ff.count == 4'd1;
   assign fire      = rsp_valid && rsp_ready;
   assign free      = (frm_ff.count == 4'd0) || (rsp_ready && rsp_last);

   always_comb begin
      frm_in = frm_ff;
      if (load) begin
         frm_in = frame;
      end else if (fire) begin
         frm_in.bytes = {frm_ff.bytes[FRAME_BITS-9:0], 8'h00};
         frm_in.count = frm_ff.count - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frm_ff <= '0;
      end else begin
         frm_ff <= frm_in;
      end
   end

   assign rsp_tx_valid  = frm_ff.tx;
   assign rsp_tx_byte   = frm_ff.bytes[FRAME_BITS-1 -: 8];
   assign rsp_done_res  = frm_ff.done && rsp_last;
   assign rsp_status    = frm_ff.status;
   assign rsp_read_data = frm_ff.read_data;

   `SCFP_ASSERT_NOW(a_load_when_free, load, free, "frame loaded over pending results")
   `SCFP_ASSERT_NEXT(a_count_steps, fire && !rsp_last, frm_ff.count == $past(frm_ff.count) - 4'd1, "result count skipped")
   `SCFP_ASSERT_NOW(a_count_bound, rsp_valid, frm_ff.count <= 4'd12, "result count beyond a frame")

endmodule

>>> design/spi_command_framer_with_poll.sv
// ----------------------------------------------------------------------------
// SPI command framer with response poll - top level
// Host-side command framing, burst data, ready polling and read assembly.
// ----------------------------------------------------------------------------
// Each accepted item lands in an input register; the next cycle the decoder
// checks it against the command state and builds a frame of up to twelve
// results, which load into the serializer. The serializer presents one result
// per cycle while rsp_ready is high. An item causes 12 results for a single
// or first burst write, 9 for a read start, 4 for a burst word, 1 for a
// response byte, a rejected command or a non-FSM command, and none for a
// burst word or response byte outside its phase. The next item is taken
// while the serializer still drains: once its final result goes out, the
// following frame loads in the same cycle, so the output side runs without
// gaps. The first result reaches the port once its item has loaded into a free
// serializer. Configuration writes take effect at the edge that ends the
// access cycle and must land only while the block is idle.
// ----------------------------------------------------------------------------
module spi_command_framer_with_poll
   import scfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_command,
   input  logic [2:0]  req_granularity,
   input  logic [31:0] req_address,
   input  logic [15:0] req_length,
   input  logic [31:0] req_data_word,
   input  logic [7:0]  req_rx_byte,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_data,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // input register: holds one item until the decoder can pass it on
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  op_ff;
   logic [3:0]  cmd_ff;
   logic [2:0]  gran_ff;
   logic [31:0] addr_ff;
   logic [15:0] len_ff;
   logic [31:0] data_ff;
   logic [7:0]  rx_ff;

   logic        req_fire;
   logic        advance;
   logic        ser_free;
   frame_type   frame;
   logic [15:0] poll_limit;
   logic [15:0] max_burst;

   scfp_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .poll_limit (poll_limit),
      .max_burst  (max_burst)
   );

   // Advance the held item when it causes nothing, or when the serializer
   // is empty or hands out its final result this cycle.
   assign advance   = in_valid_ff && ((frame.count == 4'd0) || ser_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_operation;
         cmd_ff  <= req_command;
         gran_ff <= req_granularity;
         addr_ff <= req_address;
         len_ff  <= req_length;
         data_ff <= req_data_word;
         rx_ff   <= req_rx_byte;
      end
   end

   scfp_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .operation   (op_ff),
      .command     (cmd_ff),
      .granularity (gran_ff),
      .address     (addr_ff),
      .length      (len_ff),
      .data_word   (data_ff),
      .rx_byte     (rx_ff),
      .poll_limit  (poll_limit),
      .max_burst   (max_burst),
      .frame       (frame)
   );

   // load only frames that carry results; empty ones just update state
   scfp_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .load          (advance && (frame.count != 4'd0)),
      .frame         (frame),
      .free          (ser_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_valid  (rsp_tx_valid),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last      (rsp_last),
      .rsp_done_res  (rsp_done_res),
      .rsp_status    (rsp_status),
      .rsp_read_data (rsp_read_data)
   );

endmodule
